>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Condition checked at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Types, codes and reserved word table of the token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MAX_IDENT_LEN    = 32;
  localparam int MAX_COMMENT_NEST = 16;
  localparam int IDX_W            = $clog2(MAX_IDENT_LEN);
  localparam int LEN_W            = 6;
  localparam int DEPTH_W          = 5;
  localparam int NUM_WORDS        = 25;
  localparam int WORD_MAX         = 9;

  localparam logic [30:0] NUM_DIV10 = 31'd214748364;
  localparam logic [3:0]  NUM_MOD10 = 4'd7;

  typedef enum logic [2:0] {
    M_IDLE, M_NUMBER, M_IDENT, M_STRING, M_COMMENT, M_GT, M_LT, M_COLON
  } mode_t;

  typedef enum logic [2:0] {
    ST_IN, ST_MODE, ST_CHAR, ST_RESCAN, ST_HALT
  } ctl_state_t;

  typedef enum logic [1:0] {PH_MODE, PH_CHAR, PH_RESCAN} phase_t;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_STR   = 2'd1;
  localparam logic [1:0] KIND_IDENT = 2'd2;

  localparam logic [5:0] TK_IDENT  = 6'd25;
  localparam logic [5:0] TK_NUMBER = 6'd26;
  localparam logic [5:0] TK_STRING = 6'd27;
  localparam logic [5:0] TK_EQ     = 6'd28;
  localparam logic [5:0] TK_GE     = 6'd29;
  localparam logic [5:0] TK_GT     = 6'd30;
  localparam logic [5:0] TK_LE     = 6'd31;
  localparam logic [5:0] TK_NE     = 6'd32;
  localparam logic [5:0] TK_LT     = 6'd33;
  localparam logic [5:0] TK_MINUS  = 6'd34;
  localparam logic [5:0] TK_PLUS   = 6'd35;
  localparam logic [5:0] TK_DIV    = 6'd36;
  localparam logic [5:0] TK_MUL    = 6'd37;
  localparam logic [5:0] TK_RBRACK = 6'd38;
  localparam logic [5:0] TK_RPAREN = 6'd39;
  localparam logic [5:0] TK_COMMA  = 6'd40;
  localparam logic [5:0] TK_DOT    = 6'd41;
  localparam logic [5:0] TK_ASSIGN = 6'd42;
  localparam logic [5:0] TK_LBRACK = 6'd43;
  localparam logic [5:0] TK_LPAREN = 6'd44;
  localparam logic [5:0] TK_SEMI   = 6'd45;
  localparam logic [5:0] TK_EOF    = 6'd46;
  localparam logic [5:0] TK_NONE   = 6'd0;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_ILLEGAL   = 4'd1;
  localparam logic [3:0] ERR_NUM_BIG   = 4'd2;
  localparam logic [3:0] ERR_ID_LONG   = 4'd3;
  localparam logic [3:0] ERR_ESCAPE    = 4'd4;
  localparam logic [3:0] ERR_STR_OPEN  = 4'd5;
  localparam logic [3:0] ERR_STR_CTRL  = 4'd6;
  localparam logic [3:0] ERR_CMT_OPEN  = 4'd7;
  localparam logic [3:0] ERR_CMT_DEEP  = 4'd8;

  localparam logic [8*WORD_MAX-1:0] WORD_TEXT [NUM_WORDS] = '{
    "and", "array", "begin", "boolean", "call", "do", "else", "elsif", "end",
    "false", "function", "get", "if", "integer", "leave", "not", "or", "put",
    "relax", "rem", "source", "then", "to", "true", "while"
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd3, 4'd5, 4'd5, 4'd7, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd3,
    4'd2, 4'd7, 4'd5, 4'd3, 4'd2, 4'd3, 4'd5, 4'd3, 4'd6, 4'd4, 4'd2, 4'd4,
    4'd5
  };

  // Words whose character at position pos equals ch.
  function automatic logic [NUM_WORDS-1:0] word_match(input logic [LEN_W-1:0] pos,
                                                      input logic [7:0] ch);
    logic [NUM_WORDS-1:0] m;
    int sh;
    m = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      sh = 8 * (int'(WORD_LEN[w]) - 1 - int'(pos));
      if (int'(pos) < int'(WORD_LEN[w]))
        m[w] = (WORD_TEXT[w][sh +: 8] == ch);
    end
    return m;
  endfunction

  // Token code of a finished name: reserved word or identifier.
  function automatic logic [5:0] word_code(input logic [NUM_WORDS-1:0] m,
                                           input logic [LEN_W-1:0] len);
    logic [5:0] code;
    code = TK_IDENT;
    for (int w = NUM_WORDS - 1; w >= 0; w--)
      if (m[w] && ({2'b0, WORD_LEN[w]} == len))
        code = 6'(w);
    return code;
  endfunction

  typedef struct packed {
    phase_t phase;
    logic   fire;
    logic   last;
  } lts_cmd_t;

  typedef struct packed {
    logic emit;
    logic fail;
    logic do_rescan;
    logic need_chars;
    logic rescan_emit;
    logic char_done;
    logic slot_free;
  } lts_sts_t;

endpackage

>>> sv/lts_if.sv
// ----------------------------------------------------------------------------
// lts_in_if / lts_out_if
// Valid/ready channels of the token scanner.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_file;
  modport source (output valid, char_code, end_of_file, input ready);
  modport sink   (input valid, char_code, end_of_file, output ready);
endinterface

interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [5:0]  token_code;
  logic [30:0] value;
  logic [3:0]  error_code;
  logic [15:0] line;
  logic [15:0] column;
  logic        last;
  modport source (output valid, item_kind, token_code, value, error_code, line, column,
                  last, input ready);
  modport sink   (input valid, item_kind, token_code, value, error_code, line, column,
                  last, output ready);
endinterface

>>> sv/language_token_scanner.sv
// ----------------------------------------------------------------------------
// language_token_scanner
// Lexical scanner: one source byte or end-of-file mark per input beat,
// zero or more token / character beats out.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  : valid/ready; a beat carries char_code and end_of_file.
//  out_ch : valid/ready; a beat carries one token, string character or
//           identifier character, with last set on the final beat that an
//           input beat causes.
//  Steps  : the block takes one input beat at a time. A byte that extends
//           a pending token or closes one in place (>=, <=, <>, :=, string
//           and comment bytes) passes through accept and mode step; a byte
//           seen from idle passes through accept, mode step and rescan. A
//           finished identifier that is no reserved word adds a step per name
//           character, read one ahead from the name buffer RAM. Mode step and
//           rescan results are both written to the result register.
//  Stall  : a single result register separates the sides; the sequencer
//           holds its step while that register is full and not drained.
//  Reset  : rst_n synchronous, active low; scanner idle, line 1, column 0.
//           After any error beat the block keeps accepting input beats and
//           drops them until the next reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module language_token_scanner (
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch
);
  import lts_pkg::*;

  lts_cmd_t cmd;
  lts_sts_t sts;
  logic     in_ready;
  logic     in_accept;

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  // Sequencer: byte accept, mode step, name characters, rescan.
  lts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  // Datapath with scan state and result register.
  lts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_char   (in_ch.char_code),
    .in_eof    (in_ch.end_of_file),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.item_kind),
    .out_code  (out_ch.token_code),
    .out_value (out_ch.value),
    .out_err   (out_ch.error_code),
    .out_line  (out_ch.line),
    .out_col   (out_ch.column),
    .out_last  (out_ch.last)
  );

  // A step never runs while a new byte is being taken.
  `ASSERT_IMPLY(a_no_overlap, clk, rst_n, cmd.fire, !in_ready)
  // A result is only written when the result register is free.
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.fire && sts.emit, sts.slot_free)
  // Name character beats never carry an error.
  `ASSERT_ALWAYS(a_char_no_fail, clk, rst_n, !(cmd.phase == PH_CHAR && sts.fail))
endmodule

>>> sv/lts_ram.sv
// ----------------------------------------------------------------------------
// lts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end
endmodule

>>> sv/lts_ctrl.sv
// ----------------------------------------------------------------------------
// lts_ctrl
// Sequencer: accept a byte, run the mode step, stream name characters,
// then rescan the byte; parks in halt after an error.
// ----------------------------------------------------------------------------
module lts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  lts_pkg::lts_sts_t sts,
  output lts_pkg::lts_cmd_t cmd,
  output logic              in_ready
);
  import lts_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IN;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.phase = PH_MODE;
    cmd.fire  = 1'b0;
    cmd.last  = 1'b1;
    in_ready  = 1'b0;
    case (state_r)
      ST_IN: begin
        in_ready = 1'b1;
        if (in_accept) state_nxt = ST_MODE;
      end
      ST_MODE: begin
        cmd.fire = !sts.emit || sts.slot_free;
        cmd.last = sts.fail || !(sts.need_chars || (sts.do_rescan && sts.rescan_emit));
        if (cmd.fire) begin
          if (sts.fail)            state_nxt = ST_HALT;
          else if (sts.need_chars) state_nxt = ST_CHAR;
          else if (sts.do_rescan)  state_nxt = ST_RESCAN;
          else                     state_nxt = ST_IN;
        end
      end
      ST_CHAR: begin
        cmd.phase = PH_CHAR;
        cmd.fire  = sts.slot_free;
        cmd.last  = sts.char_done && !sts.rescan_emit;
        if (cmd.fire && sts.char_done) state_nxt = ST_RESCAN;
      end
      ST_RESCAN: begin
        cmd.phase = PH_RESCAN;
        cmd.fire  = !sts.emit || sts.slot_free;
        if (cmd.fire) state_nxt = sts.fail ? ST_HALT : ST_IN;
      end
      ST_HALT: begin
        in_ready = 1'b1;
      end
      default: state_nxt = ST_IN;
    endcase
  end
endmodule

>>> sv/lts_dp.sv
// ----------------------------------------------------------------------------
// lts_dp
// Scanner datapath: position counters, mode registers, name buffer,
// number accumulator and the result register.
// ----------------------------------------------------------------------------
module lts_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        in_char,
  input  logic              in_eof,
  input  lts_pkg::lts_cmd_t cmd,
  output lts_pkg::lts_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [5:0]        out_code,
  output logic [30:0]       out_value,
  output logic [3:0]        out_err,
  output logic [15:0]       out_line,
  output logic [15:0]       out_col,
  output logic              out_last
);
  import lts_pkg::*;

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction
  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction
  function automatic logic is_space(input logic [7:0] ch);
    return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  logic [7:0]           c_r;
  logic                 eof_r;
  mode_t                mode_r, mode_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [NUM_WORDS-1:0] mask_r, mask_nxt;
  logic [30:0]          acc_r, acc_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic                 esc_r, esc_nxt;
  logic [15:0]          line_r, col_r, sline_r, scol_r, sline_nxt, scol_nxt;
  logic                 nl_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 out_valid_r;

  logic        e_emit, e_fail, e_rescan;
  logic [1:0]  e_kind;
  logic [5:0]  e_code;
  logic [30:0] e_value;
  logic [3:0]  e_err;
  logic [15:0] e_line, e_col;
  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  logic       name_ch, ch_ok;
  logic [3:0] dig;
  logic [5:0] id_code;
  logic [15:0] line_base, col_base;
  logic [DEPTH_W-1:0] depth_dec;

  assign dig       = c_r[3:0] - 4'd0;
  assign name_ch   = is_alpha(c_r) || is_digit(c_r) || c_r == "_";
  assign ch_ok     = !eof_r;
  assign id_code   = word_code(mask_r, len_r);
  assign depth_dec = (depth_r != '0) ? depth_r - 1'b1 : depth_r;

  // Position update on each accepted byte.
  assign line_base = (nl_r && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
  assign col_base  = nl_r ? 16'd0 : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 16'd1;
      col_r  <= 16'd0;
      nl_r   <= 1'b0;
    end else if (in_accept && !in_eof) begin
      line_r <= line_base;
      col_r  <= (col_base != 16'hFFFF) ? col_base + 16'd1 : col_base;
      nl_r   <= (in_char == 8'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      c_r   <= in_char;
      eof_r <= in_eof;
    end
  end

  always_comb begin
    e_emit = 1'b0; e_fail = 1'b0; e_rescan = 1'b0;
    e_kind = KIND_TOKEN; e_code = TK_NONE; e_value = '0; e_err = ERR_NONE;
    e_line = sline_r; e_col = scol_r;
    mode_nxt = mode_r; len_nxt = len_r; mask_nxt = mask_r; acc_nxt = acc_r;
    depth_nxt = depth_r; esc_nxt = esc_r; sline_nxt = sline_r; scol_nxt = scol_r;
    idx_nxt = idx_r;
    ram_we = 1'b0; ram_waddr = len_r[IDX_W-1:0]; ram_wdata = c_r;
    case (cmd.phase)
      PH_MODE: begin
        idx_nxt = '0;
        case (mode_r)
          M_NUMBER: begin
            if (ch_ok && is_digit(c_r)) begin
              if (acc_r > NUM_DIV10 || (acc_r == NUM_DIV10 && dig > NUM_MOD10)) begin
                e_fail = 1'b1; e_err = ERR_NUM_BIG;
              end else begin
                acc_nxt = (acc_r << 3) + (acc_r << 1) + {27'd0, dig};
              end
            end else begin
              e_emit = 1'b1; e_code = TK_NUMBER; e_value = acc_r; e_rescan = 1'b1;
            end
          end
          M_IDENT: begin
            if (ch_ok && name_ch) begin
              if (len_r >= LEN_W'(MAX_IDENT_LEN)) begin
                e_fail = 1'b1; e_err = ERR_ID_LONG;
              end else begin
                ram_we   = 1'b1;
                len_nxt  = len_r + 1'b1;
                mask_nxt = mask_r & word_match(len_r, c_r);
              end
            end else begin
              e_emit = 1'b1; e_code = id_code; e_rescan = 1'b1;
            end
          end
          M_GT: begin
            if (ch_ok && c_r == "=") begin
              e_emit = 1'b1; e_code = TK_GE; mode_nxt = M_IDLE;
            end else begin
              e_emit = 1'b1; e_code = TK_GT; e_rescan = 1'b1;
            end
          end
          M_LT: begin
            if (ch_ok && c_r == "=") begin
              e_emit = 1'b1; e_code = TK_LE; mode_nxt = M_IDLE;
            end else if (ch_ok && c_r == ">") begin
              e_emit = 1'b1; e_code = TK_NE; mode_nxt = M_IDLE;
            end else begin
              e_emit = 1'b1; e_code = TK_LT; e_rescan = 1'b1;
            end
          end
          M_COLON: begin
            if (ch_ok && c_r == "=") begin
              e_emit = 1'b1; e_code = TK_ASSIGN; mode_nxt = M_IDLE;
            end else begin
              e_fail = 1'b1; e_err = ERR_ILLEGAL;
            end
          end
          M_STRING: begin
            if (eof_r) begin
              e_fail = 1'b1;
              if (esc_r) begin
                e_err = ERR_ESCAPE; e_line = line_r; e_col = col_r;
              end else begin
                e_err = ERR_STR_OPEN;
              end
            end else if (esc_r) begin
              if (c_r == "n" || c_r == "t" || c_r == "\"" || c_r == "\\") begin
                e_emit = 1'b1; e_kind = KIND_STR; e_code = TK_STRING;
                e_value = {23'd0, c_r}; esc_nxt = 1'b0;
              end else begin
                e_fail = 1'b1; e_err = ERR_ESCAPE; e_line = line_r; e_col = col_r - 16'd1;
              end
            end else if (c_r == "\"") begin
              e_emit = 1'b1; e_code = TK_STRING; mode_nxt = M_IDLE;
            end else if (c_r == "\\") begin
              e_emit = 1'b1; e_kind = KIND_STR; e_code = TK_STRING;
              e_value = {23'd0, c_r}; esc_nxt = 1'b1;
            end else if (c_r < 8'h20 || c_r >= 8'h7F) begin
              e_fail = 1'b1; e_err = ERR_STR_CTRL; e_line = line_r; e_col = col_r;
            end else begin
              e_emit = 1'b1; e_kind = KIND_STR; e_code = TK_STRING; e_value = {23'd0, c_r};
            end
          end
          M_COMMENT: begin
            if (eof_r) begin
              e_fail = 1'b1; e_err = ERR_CMT_OPEN;
            end else if (c_r == "{") begin
              if (depth_r >= DEPTH_W'(MAX_COMMENT_NEST)) begin
                e_fail = 1'b1; e_err = ERR_CMT_DEEP; e_line = line_r; e_col = col_r;
              end else begin
                depth_nxt = depth_r + 1'b1;
              end
            end else if (c_r == "}") begin
              depth_nxt = depth_dec;
              if (depth_dec == '0) mode_nxt = M_IDLE;
            end
          end
          default: e_rescan = 1'b1;
        endcase
        if (e_fail) mode_nxt = M_IDLE;
      end
      PH_CHAR: begin
        e_emit  = 1'b1; e_kind = KIND_IDENT; e_code = TK_IDENT;
        e_value = {23'd0, ram_rdata};
        idx_nxt = idx_r + 1'b1;
      end
      default: begin
        // Rescan: the byte seen from the idle state, or end of file.
        mode_nxt = M_IDLE;
        if (eof_r) begin
          e_emit = 1'b1; e_code = TK_EOF; e_line = line_r; e_col = col_r;
        end else if (!is_space(c_r)) begin
          sline_nxt = line_r; scol_nxt = col_r;
          e_line = line_r; e_col = col_r;
          if (is_alpha(c_r) || c_r == "_") begin
            ram_we = 1'b1; ram_waddr = '0;
            len_nxt = LEN_W'(1); mask_nxt = word_match('0, c_r); mode_nxt = M_IDENT;
          end else if (is_digit(c_r)) begin
            acc_nxt = {27'd0, dig}; mode_nxt = M_NUMBER;
          end else begin
            case (c_r)
              "\"":    begin esc_nxt = 1'b0; mode_nxt = M_STRING; end
              "{":     begin depth_nxt = DEPTH_W'(1); mode_nxt = M_COMMENT; end
              ">":     mode_nxt = M_GT;
              "<":     mode_nxt = M_LT;
              ":":     mode_nxt = M_COLON;
              "=":     begin e_emit = 1'b1; e_code = TK_EQ;     end
              "-":     begin e_emit = 1'b1; e_code = TK_MINUS;  end
              "+":     begin e_emit = 1'b1; e_code = TK_PLUS;   end
              "/":     begin e_emit = 1'b1; e_code = TK_DIV;    end
              "*":     begin e_emit = 1'b1; e_code = TK_MUL;    end
              "]":     begin e_emit = 1'b1; e_code = TK_RBRACK; end
              ")":     begin e_emit = 1'b1; e_code = TK_RPAREN; end
              ",":     begin e_emit = 1'b1; e_code = TK_COMMA;  end
              ".":     begin e_emit = 1'b1; e_code = TK_DOT;    end
              "[":     begin e_emit = 1'b1; e_code = TK_LBRACK; end
              "(":     begin e_emit = 1'b1; e_code = TK_LPAREN; end
              ";":     begin e_emit = 1'b1; e_code = TK_SEMI;   end
              default: begin e_fail = 1'b1; e_err = ERR_ILLEGAL; end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      len_r   <= '0;
      mask_r  <= '0;
      acc_r   <= '0;
      depth_r <= '0;
      esc_r   <= 1'b0;
      sline_r <= 16'd1;
      scol_r  <= 16'd0;
      idx_r   <= '0;
    end else if (cmd.fire) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      mask_r  <= mask_nxt;
      acc_r   <= acc_nxt;
      depth_r <= depth_nxt;
      esc_r   <= esc_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Read one ahead so the next name character is ready when it is sent.
  assign ram_raddr = (cmd.phase == PH_CHAR) ? (cmd.fire ? idx_r + 1'b1 : idx_r) : '0;

  lts_ram #(.WIDTH(8), .DEPTH(MAX_IDENT_LEN)) u_name_buf (
    .clk     (clk),
    .we      (ram_we && cmd.fire),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n)                       out_valid_r <= 1'b0;
    else if (cmd.fire && (e_emit || e_fail)) out_valid_r <= 1'b1;
    else if (out_ready)               out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && (e_emit || e_fail)) begin
      out_kind  <= e_kind;
      out_code  <= e_code;
      out_value <= e_value;
      out_err   <= e_err;
      out_line  <= e_line;
      out_col   <= e_col;
      out_last  <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.emit        = e_emit || e_fail;
  assign sts.fail        = e_fail;
  assign sts.do_rescan   = e_rescan;
  assign sts.need_chars  = (mode_r == M_IDENT) && !(ch_ok && name_ch) && (id_code == TK_IDENT);
  assign sts.rescan_emit = eof_r || !(is_space(c_r) || name_ch || c_r == "\"" ||
                           c_r == "{" || c_r == ">" || c_r == "<" || c_r == ":");
  assign sts.char_done   = (idx_r == IDX_W'(len_r - 1'b1));
  assign sts.slot_free   = !out_valid_r || out_ready;
endmodule
